// ===== rtl/core/iresc_pkg.sv =====
// Shared types and constants for the IR edge segment capture core.
// No dependencies; taken in by the interfaces and the core.
package iresc_pkg;

    localparam int ELAPSED_W  = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 10;
    localparam int THRESH_W   = 12;
    localparam int MIN_SEG_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WAIT    = 3'd1,
        MODE_CAPT    = 3'd2,
        MODE_DONE    = 3'd3,
        MODE_TIMEOUT = 3'd4,
        MODE_FULL    = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_THRESHOLD = 3'd0,
        CFG_MIN_SEGMENT    = 3'd1,
        CFG_IDLE_END       = 3'd2,
        CFG_MAX_SEGMENT    = 3'd3,
        CFG_TIMEOUT        = 3'd4,
        CFG_MAX_SEGMENTS   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    localparam logic [THRESH_W-1:0]  RST_EDGE_THRESHOLD = 12'd200;
    localparam logic [MIN_SEG_W-1:0] RST_MIN_SEGMENT    = 16'd10;
    localparam logic [TIME_W-1:0]    RST_IDLE_END       = 32'd20000;
    localparam logic [TIME_W-1:0]    RST_MAX_SEGMENT    = 32'd2147483647;
    localparam logic [TIME_W-1:0]    RST_TIMEOUT        = 32'd15000000;
    localparam logic [COUNT_W-1:0]   RST_MAX_SEGMENTS   = 10'd510;

endpackage

// ===== rtl/core/iresc_ifs.sv =====
// Valid/ready channel interfaces for the capture core: sample words in,
// segment result words out. Depends on iresc_pkg.
interface iresc_item_if
    import iresc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;
    logic [ELAPSED_W-1:0]   elapsed_us;

    modport source (output valid, output cmd, output sample, output elapsed_us,
                    input ready);
    modport sink   (input valid, input cmd, input sample, input elapsed_us,
                    output ready);
endinterface

interface iresc_result_if
    import iresc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         capture_state;
    logic               segment_valid;
    logic               segment_mark;
    logic [TIME_W-1:0]  segment_duration_us;
    logic [COUNT_W-1:0] segment_count;

    modport source (output valid, output capture_state, output segment_valid,
                    output segment_mark, output segment_duration_us,
                    output segment_count, input ready);
    modport sink   (input valid, input capture_state, input segment_valid,
                    input segment_mark, input segment_duration_us,
                    input segment_count, output ready);
endinterface

// ===== rtl/core/ir_edge_segment_capture_core.sv =====
// IR edge segment capture core: pulse-width capture from an ADC sample stream.
// Each accepted word's result word is registered and offered in the cycle after it is taken.
// Throughput: one word per cycle when not stalled; the bound is the state
// feedback loop (saturating timer add followed by the threshold compares).
// Reset: capture idle, timers and count zero, registers at their defaults.
// Depends on iresc_pkg and the channel interfaces in iresc_ifs.sv.
module ir_edge_segment_capture_core
    import iresc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    iresc_item_if.sink            item,
    iresc_result_if.source        result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    // configuration
    logic [THRESH_W-1:0]  edge_threshold_reg;
    logic [MIN_SEG_W-1:0] min_segment_reg;
    logic [TIME_W-1:0]    idle_end_reg;
    logic [TIME_W-1:0]    max_segment_reg;
    logic [TIME_W-1:0]    timeout_reg;
    logic [COUNT_W-1:0]   max_segments_reg;

    // capture state
    mode_t                  mode_reg, mode_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   level_reg, level_next;
    logic [TIME_W-1:0]      seg_time_reg, seg_time_next;
    logic [TIME_W-1:0]      sess_time_reg, sess_time_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    // result word
    logic               out_valid_reg;
    mode_t              res_state_reg;
    logic               res_seg_valid_reg, res_seg_valid_next;
    logic               res_mark_reg, res_mark_next;
    logic [TIME_W-1:0]  res_dur_reg, res_dur_next;
    logic [COUNT_W-1:0] res_count_reg;

    logic                   accept;
    logic [TIME_W:0]        seg_sum, sess_sum;
    logic [TIME_W-1:0]      seg_sat, sess_sat;
    logic                   step_up;
    logic [SAMPLE_BITS-1:0] step_diff;
    logic                   is_edge;
    logic                   buf_full;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid               = out_valid_reg;
    assign result.capture_state       = res_state_reg;
    assign result.segment_valid       = res_seg_valid_reg;
    assign result.segment_mark        = res_mark_reg;
    assign result.segment_duration_us = res_dur_reg;
    assign result.segment_count       = res_count_reg;

    assign seg_sum  = {1'b0, seg_time_reg} + {{(TIME_W-ELAPSED_W+1){1'b0}}, item.elapsed_us};
    assign sess_sum = {1'b0, sess_time_reg} + {{(TIME_W-ELAPSED_W+1){1'b0}}, item.elapsed_us};
    // saturate on carry out
    assign seg_sat  = seg_sum[TIME_W]  ? {TIME_W{1'b1}} : seg_sum[TIME_W-1:0];
    assign sess_sat = sess_sum[TIME_W] ? {TIME_W{1'b1}} : sess_sum[TIME_W-1:0];

    assign step_up   = item.sample > prev_reg;
    assign step_diff = step_up ? (item.sample - prev_reg) : (prev_reg - item.sample);
    assign is_edge   = CMP_W'(step_diff) > CMP_W'(edge_threshold_reg);
    assign buf_full  = count_reg >= max_segments_reg;

    always_comb
    begin
        mode_next          = mode_reg;
        prev_next          = prev_reg;
        level_next         = level_reg;
        seg_time_next      = seg_time_reg;
        sess_time_next     = sess_time_reg;
        count_next         = count_reg;
        res_seg_valid_next = 1'b0;
        res_mark_next      = 1'b0;
        res_dur_next       = '0;

        if (item.cmd == CMD_START)
        begin
            mode_next      = MODE_WAIT;
            prev_next      = item.sample;
            level_next     = 1'b0;
            seg_time_next  = '0;
            sess_time_next = '0;
            count_next     = '0;
        end
        else if (mode_reg == MODE_WAIT || mode_reg == MODE_CAPT)
        begin
            seg_time_next  = seg_sat;
            sess_time_next = sess_sat;
            if (sess_sat >= timeout_reg)
            begin
                mode_next = MODE_TIMEOUT;
            end
            else if (mode_reg == MODE_WAIT)
            begin
                if (is_edge)
                begin
                    level_next    = step_up;
                    seg_time_next = '0;
                    mode_next     = MODE_CAPT;
                end
                prev_next = item.sample;
            end
            else if (is_edge)
            begin
                if (seg_sat < TIME_W'(min_segment_reg))
                begin
                    // glitch: drop it, keep the level
                    seg_time_next = '0;
                    prev_next     = item.sample;
                end
                else if (buf_full)
                begin
                    mode_next = MODE_FULL;
                end
                else
                begin
                    count_next         = count_reg + 1'b1;
                    seg_time_next      = '0;
                    res_seg_valid_next = 1'b1;
                    res_mark_next      = !level_reg;
                    res_dur_next       = seg_sat;
                    level_next         = step_up;
                    prev_next          = item.sample;
                end
            end
            else if (level_reg && seg_sat >= idle_end_reg)
            begin
                mode_next = MODE_DONE;
            end
            else if (seg_sat >= max_segment_reg)
            begin
                // overlong: store one piece of max length, drop the excess
                if (buf_full)
                begin
                    mode_next = MODE_FULL;
                end
                else
                begin
                    count_next         = count_reg + 1'b1;
                    seg_time_next      = '0;
                    res_seg_valid_next = 1'b1;
                    res_mark_next      = !level_reg;
                    res_dur_next       = max_segment_reg;
                    prev_next          = item.sample;
                end
            end
            else
            begin
                prev_next = item.sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_threshold_reg <= RST_EDGE_THRESHOLD;
            min_segment_reg    <= RST_MIN_SEGMENT;
            idle_end_reg       <= RST_IDLE_END;
            max_segment_reg    <= RST_MAX_SEGMENT;
            timeout_reg        <= RST_TIMEOUT;
            max_segments_reg   <= RST_MAX_SEGMENTS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_MIN_SEGMENT:    min_segment_reg    <= cfg_data[MIN_SEG_W-1:0];
                CFG_IDLE_END:       idle_end_reg       <= cfg_data[TIME_W-1:0];
                CFG_MAX_SEGMENT:    max_segment_reg    <= cfg_data[TIME_W-1:0];
                CFG_TIMEOUT:        timeout_reg        <= cfg_data[TIME_W-1:0];
                CFG_MAX_SEGMENTS:   max_segments_reg   <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            prev_reg      <= '0;
            level_reg     <= 1'b0;
            seg_time_reg  <= '0;
            sess_time_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                prev_reg      <= prev_next;
                level_reg     <= level_next;
                seg_time_reg  <= seg_time_next;
                sess_time_reg <= sess_time_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_state_reg     <= mode_next;
            res_seg_valid_reg <= res_seg_valid_next;
            res_mark_reg      <= res_mark_next;
            res_dur_reg       <= res_dur_next;
            res_count_reg     <= count_next;
        end
    end

endmodule

// ===== dv/ir_edge_segment_capture_core_tb.sv =====
// Self-checking testbench for ir_edge_segment_capture_core: drives sample words,
// predicts every result word from its own capture model and checks them in order.
// Depends on iresc_pkg, the channel interfaces in iresc_ifs.sv and the core.
module ir_edge_segment_capture_core_tb;
    import iresc_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct {
        cmd_t                   cmd;
        logic [SAMPLE_BITS-1:0] adc;
        logic [ELAPSED_W-1:0]   elapsed;
    } sample_word_t;

    typedef struct packed {
        mode_t              state;
        logic               valid;
        logic               mark;
        logic [TIME_W-1:0]  dur;
        logic [COUNT_W-1:0] count;
    } capture_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    iresc_item_if #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
    iresc_result_if result_ch ();

    ir_edge_segment_capture_core #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies and capture state of the predictor
    logic [THRESH_W-1:0]    thr_reg;
    logic [MIN_SEG_W-1:0]   min_seg_reg;
    logic [TIME_W-1:0]      idle_end_reg;
    logic [TIME_W-1:0]      max_seg_reg;
    logic [TIME_W-1:0]      timeout_reg;
    logic [COUNT_W-1:0]     max_segs_reg;
    mode_t                  cap_mode;
    logic [SAMPLE_BITS-1:0] prev_sample;
    logic                   level_high;
    logic [TIME_W-1:0]      seg_time;
    logic [TIME_W-1:0]      sess_time;
    logic [COUNT_W-1:0]     stored_cnt;

    sample_word_t    pending_words[$];
    capture_result_t expected_segments[$];
    sample_word_t    next_word;
    capture_result_t want;

    int cycle_cnt = 0;
    int offered_cnt = 0;
    int results_seen = 0;
    int mismatches = 0;
    int holdoff_left = 0;
    bit holdoff_fired = 1'b0;
    bit calm;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    assign calm = (offered_cnt >= 700) && (offered_cnt < 900);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [ELAPSED_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + b;
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic capture_result_t store_piece(input logic [TIME_W-1:0] d);
        capture_result_t p;
        p = '0;
        p.valid = 1'b1;
        p.mark = !level_high;
        p.dur = d;
        stored_cnt = stored_cnt + 1'b1;
        seg_time = '0;
        return p;
    endfunction

    function automatic capture_result_t predict_capture(input sample_word_t w);
        capture_result_t        r;
        logic [SAMPLE_BITS-1:0] diff;
        logic                   up;
        r = '0;
        if (w.cmd == CMD_START)
        begin
            cap_mode = MODE_WAIT;
            prev_sample = w.adc;
            level_high = 1'b0;
            seg_time = '0;
            sess_time = '0;
            stored_cnt = '0;
        end
        else if (cap_mode == MODE_WAIT || cap_mode == MODE_CAPT)
        begin
            seg_time = sat_add(seg_time, w.elapsed);
            sess_time = sat_add(sess_time, w.elapsed);
            up = w.adc > prev_sample;
            diff = up ? w.adc - prev_sample : prev_sample - w.adc;
            if (sess_time >= timeout_reg)
                cap_mode = MODE_TIMEOUT;
            else if (cap_mode == MODE_WAIT)
            begin
                if (diff > thr_reg)
                begin
                    level_high = up;
                    seg_time = '0;
                    cap_mode = MODE_CAPT;
                end
                prev_sample = w.adc;
            end
            else if (diff > thr_reg)
            begin
                // short pulse: glitch, keep the level
                if (seg_time < min_seg_reg)
                begin
                    seg_time = '0;
                    prev_sample = w.adc;
                end
                else if (stored_cnt >= max_segs_reg)
                    cap_mode = MODE_FULL;
                else
                begin
                    r = store_piece(seg_time);
                    level_high = up;
                    prev_sample = w.adc;
                end
            end
            else if (level_high && seg_time >= idle_end_reg)
                cap_mode = MODE_DONE;
            else if (seg_time >= max_seg_reg)
            begin
                if (stored_cnt >= max_segs_reg)
                    cap_mode = MODE_FULL;
                else
                begin
                    r = store_piece(max_seg_reg);
                    prev_sample = w.adc;
                end
            end
            else
                prev_sample = w.adc;
        end
        r.state = cap_mode;
        r.count = stored_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= 50)
            $display("result %0d: %s got %0h, expected %0h", results_seen, field, got,
                     exp_val);
    endtask

    // Driver: predict each word as it goes onto the channel, hold it until taken
    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 8))
            begin
                next_word = pending_words.pop_front();
                expected_segments.push_back(predict_capture(next_word));
                item_ch.valid <= 1'b1;
                item_ch.cmd <= next_word.cmd;
                item_ch.sample <= next_word.adc;
                item_ch.elapsed_us <= next_word.elapsed;
                offered_cnt <= offered_cnt + 1;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Long receiver hold-off, once, while plenty of words are queued
    always @(posedge clk)
    begin
        if (!rst_n)
            holdoff_left <= 0;
        else if (!holdoff_fired && offered_cnt >= 400 && pending_words.size() > 50)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_fired <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Monitor: compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_segments.size() == 0)
                    report_mismatch("unexpected word", 32'(result_ch.capture_state), 0);
                else
                begin
                    want = expected_segments.pop_front();
                    if (result_ch.capture_state !== want.state)
                        report_mismatch("capture_state", 32'(result_ch.capture_state),
                                        32'(want.state));
                    if (result_ch.segment_valid !== want.valid)
                        report_mismatch("segment_valid", 32'(result_ch.segment_valid),
                                        32'(want.valid));
                    if (result_ch.segment_mark !== want.mark)
                        report_mismatch("segment_mark", 32'(result_ch.segment_mark),
                                        32'(want.mark));
                    if (result_ch.segment_duration_us !== want.dur)
                        report_mismatch("segment_duration_us",
                                        result_ch.segment_duration_us, want.dur);
                    if (result_ch.segment_count !== want.count)
                        report_mismatch("segment_count", 32'(result_ch.segment_count),
                                        32'(want.count));
                end
                results_seen <= results_seen + 1;
            end
            result_ch.ready <= (holdoff_left == 0) && (calm || $urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_word(input cmd_t c, input int unsigned s, input int unsigned e);
        sample_word_t w;
        w.cmd = c;
        w.adc = s[SAMPLE_BITS-1:0];
        w.elapsed = e[ELAPSED_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic program_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_EDGE_THRESHOLD: thr_reg = val[THRESH_W-1:0];
            CFG_MIN_SEGMENT:    min_seg_reg = val[MIN_SEG_W-1:0];
            CFG_IDLE_END:       idle_end_reg = val;
            CFG_MAX_SEGMENT:    max_seg_reg = val;
            CFG_TIMEOUT:        timeout_reg = val;
            CFG_MAX_SEGMENTS:   max_segs_reg = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [THRESH_W-1:0] thr,
                                  input logic [MIN_SEG_W-1:0] min_seg,
                                  input logic [TIME_W-1:0] idle_end,
                                  input logic [TIME_W-1:0] max_seg,
                                  input logic [TIME_W-1:0] tmo,
                                  input logic [COUNT_W-1:0] max_segs);
        program_reg(CFG_EDGE_THRESHOLD, 32'(thr));
        program_reg(CFG_MIN_SEGMENT, 32'(min_seg));
        program_reg(CFG_IDLE_END, idle_end);
        program_reg(CFG_MAX_SEGMENT, max_seg);
        program_reg(CFG_TIMEOUT, tmo);
        program_reg(CFG_MAX_SEGMENTS, 32'(max_segs));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain everything in flight before touching the registers
    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_segments.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned rand_elapsed();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 0;
        else if (pick < 60)
            return $urandom_range(1, 1000);
        else if (pick < 85)
            return $urandom_range(1000, 20000);
        else if (pick < 95)
            return $urandom_range(20000, 65535);
        return 65535;
    endfunction

    // One capture session: optional baseline start, then two levels with
    // sub-threshold noise, random holds, a little wideband noise and rare restarts
    task automatic gen_session(input int n, input bit with_start);
        int lo;
        int hi;
        int nz;
        int v;
        bit at_high;
        if (thr_reg > 1500)
        begin
            lo = 0;
            hi = 4095;
            nz = 0;
        end
        else
        begin
            nz = thr_reg / 3;
            lo = $urandom_range(0, 1000);
            hi = $urandom_range(lo + thr_reg + 2 * nz + 1, 4095);
        end
        at_high = 1'b1;
        if (with_start)
            push_word(CMD_START, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : hi,
                      $urandom_range(0, 65535));
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < 35)
                at_high = !at_high;
            if ($urandom_range(0, 99) < 8)
                v = $urandom_range(0, 4095);
            else
            begin
                v = (at_high ? hi : lo) + int'($urandom_range(0, 2 * nz)) - nz;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
            push_word(($urandom_range(0, 99) < 3) ? CMD_START : CMD_SAMPLE, v, rand_elapsed());
        end
    endtask

    initial
    begin
        int added;
        int n;
        logic [THRESH_W-1:0] thr;

        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_START;
        item_ch.sample = '0;
        item_ch.elapsed_us = '0;
        result_ch.ready = 1'b0;
        thr_reg = RST_EDGE_THRESHOLD;
        min_seg_reg = RST_MIN_SEGMENT;
        idle_end_reg = RST_IDLE_END;
        max_seg_reg = RST_MAX_SEGMENT;
        timeout_reg = RST_TIMEOUT;
        max_segs_reg = RST_MAX_SEGMENTS;
        cap_mode = MODE_IDLE;
        prev_sample = '0;
        level_high = 1'b0;
        seg_time = '0;
        sess_time = '0;
        stored_cnt = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset register values
        push_word(CMD_SAMPLE, 2048, 7);      // sample while idle
        push_word(CMD_START, 4095, 65535);   // elapsed of a start is ignored
        push_word(CMD_SAMPLE, 4095, 0);
        push_word(CMD_SAMPLE, 0, 5);         // first edge fixes the low level
        push_word(CMD_SAMPLE, 10, 3);
        push_word(CMD_SAMPLE, 4095, 4);      // glitch
        push_word(CMD_SAMPLE, 0, 20);
        push_word(CMD_SAMPLE, 4095, 100);
        push_word(CMD_SAMPLE, 0, 300);
        push_word(CMD_SAMPLE, 0, 65535);
        push_word(CMD_SAMPLE, 4095, 65535);
        push_word(CMD_SAMPLE, 4000, 65535);  // long high: capture done
        push_word(CMD_SAMPLE, 0, 1);         // ignored once finished
        push_word(CMD_START, 0, 0);
        push_word(CMD_SAMPLE, 4095, 1);
        push_word(CMD_START, 2000, 12);      // restart in the middle of a capture
        push_word(CMD_SAMPLE, 2201, 9);
        push_word(CMD_SAMPLE, 2001, 9);      // step equal to threshold is no edge
        push_word(CMD_SAMPLE, 1800, 65535);
        wait_idle();

        // Zero session limit: every live sample times out
        apply_settings('0, '0, '0, 32'd1, '0, 10'd1);
        for (int k = 0; k < 4; k++)
            gen_session(5, 1'b1);
        wait_idle();

        // Single-entry buffer with one-microsecond pieces
        apply_settings('0, '0, '0, 32'd1, '1, 10'd1);
        for (int k = 0; k < 3; k++)
            gen_session(10, 1'b1);
        wait_idle();

        // Every register at its maximum
        apply_settings('1, '1, '1, '1, '1, '1);
        gen_session(12, 1'b1);
        gen_session(12, 1'b1);
        wait_idle();

        // Deep buffer, captured pieces split at one microsecond
        apply_settings(12'd100, '0, '1, 32'd1, '1, '1);
        gen_session(60, 1'b1);
        gen_session(60, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            thr = ($urandom_range(0, 99) < 12) ? 12'd4094 : 12'($urandom_range(0, 1500));
            apply_settings(thr,
                           ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 2000)),
                           $urandom_range(200, 60000),
                           $urandom_range(100, 100000),
                           $urandom_range(20000, 3000000),
                           10'($urandom_range(1, 40)));
            added = 0;
            while (added < 140)
            begin
                n = $urandom_range(4, 40);
                gen_session(n, $urandom_range(0, 9) != 0);
                added += n + 1;
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
